@@ design/nbv_pkg.sv @@
// ----------------------------------------------------------------------------
// nbv_pkg: shared types and constants of the n-body Verlet step block
// Holds the datapath command codes, the controller/datapath link structs,
// the configuration bundle and the saturation helpers.
// ----------------------------------------------------------------------------
package nbv_pkg;

   // Item command codes
   localparam logic CMD_LOAD = 1'b0;
   localparam logic CMD_STEP = 1'b1;

   // Configuration register indexes
   localparam logic [2:0] REG_TIME_STEP   = 3'd0;
   localparam logic [2:0] REG_GRAV_CONST  = 3'd1;
   localparam logic [2:0] REG_SOFTENING   = 3'd2;
   localparam logic [2:0] REG_WIN_WIDTH   = 3'd3;
   localparam logic [2:0] REG_WIN_HEIGHT  = 3'd4;
   localparam logic [2:0] REG_PART_COUNT  = 3'd5;

   // Restoring divider: one quotient bit per cycle
   localparam int DIV_STEPS = 31;

   localparam logic signed [31:0] S32_MAX = 32'sh7FFF_FFFF;
   localparam logic signed [31:0] S32_MIN = 32'sh8000_0000;
   localparam logic [30:0] K_MAX = 31'h7FFF_FFFF;

   // Datapath micro-operations
   typedef enum logic [4:0] {
      OP_NONE,
      OP_LOAD,
      OP_P1_M0,
      OP_P1_M1,
      OP_P1_M2,
      OP_P1_M3,
      OP_P1_M4,
      OP_P1_M5,
      OP_P1_M6,
      OP_P1_WR,
      OP_P2_LI,
      OP_P2_D,
      OP_P2_SQX,
      OP_P2_SQY,
      OP_P2_DEN,
      OP_P2_DIVI,
      OP_P2_DIV,
      OP_P2_KX,
      OP_P2_KY,
      OP_P2_ACC,
      OP_P2_WR,
      OP_P3_SUM,
      OP_P3_MX,
      OP_P3_MY,
      OP_P3_V,
      OP_P3_RF
   } dp_op_type;

   typedef struct packed {
      dp_op_type op;
      logic      capture;
   } dp_cmd_type;

   typedef struct packed {
      logic den_zero;
      logic k_ovf;
   } dp_status_type;

   typedef struct packed {
      logic [16:0] time_step;
      logic [30:0] grav_const;
      logic [30:0] softening;
      logic [12:0] window_width;
      logic [12:0] window_height;
   } cfg_type;

   // Clamp a wide signed value to the signed 32-bit range
   function automatic logic signed [31:0] sat32(input logic signed [71:0] v);
      logic signed [31:0] r;
      if (v > 72'sd2147483647) begin
         r = S32_MAX;
      end else if (v < -72'sd2147483648) begin
         r = S32_MIN;
      end else begin
         r = v[31:0];
      end
      return r;
   endfunction

   // Negate with saturation of the most negative value
   function automatic logic signed [31:0] neg_sat(input logic signed [31:0] v);
      logic signed [31:0] r;
      if (v == S32_MIN) begin
         r = S32_MAX;
      end else begin
         r = -v;
      end
      return r;
   endfunction

endpackage

@@ design/nbv_ram.sv @@
// ----------------------------------------------------------------------------
// nbv_ram: generic simple dual-port RAM
// One write port and one read port, read data registered.
// ----------------------------------------------------------------------------
module nbv_ram #(
   parameter int WIDTH = 32,
   parameter int DEPTH = 64
) (
   input  logic                     clock,
   input  logic                     we,
   input  logic [$clog2(DEPTH)-1:0] waddr,
   input  logic [WIDTH-1:0]         wdata,
   input  logic [$clog2(DEPTH)-1:0] raddr,
   output logic [WIDTH-1:0]         rdata
);

   logic [WIDTH-1:0] mem [DEPTH];
   logic [WIDTH-1:0] rdata_ff;

   // Write and registered read
   always_ff @(posedge clock) begin
      if (we) begin
         mem[waddr] <= wdata;
      end
      rdata_ff <= mem[raddr];
   end

   assign rdata = rdata_ff;

endmodule

@@ design/nbv_dp.sv @@
// ----------------------------------------------------------------------------
// nbv_dp: datapath of the n-body Verlet step
// Particle stores, one shared 34x34 multiplier with registered product,
// a restoring divider and the reflect and result registers.
// ----------------------------------------------------------------------------
module nbv_dp #(
   parameter int MAX_PARTICLES = 64
) (
   input  logic                              clock,
   input  nbv_pkg::dp_cmd_type               cmd,
   input  logic [$clog2(MAX_PARTICLES)-1:0]  idx_i,
   input  logic [$clog2(MAX_PARTICLES)-1:0]  raddr,
   input  nbv_pkg::cfg_type                  cfg,
   input  logic [5:0]                        req_slot,
   input  logic [30:0]                       req_mass,
   input  logic signed [31:0]                req_pos_x,
   input  logic signed [31:0]                req_pos_y,
   input  logic signed [31:0]                req_vel_x,
   input  logic signed [31:0]                req_vel_y,
   input  logic [30:0]                       req_radius,
   output nbv_pkg::dp_status_type            status,
   output logic signed [31:0]                rsp_new_pos_x,
   output logic signed [31:0]                rsp_new_pos_y,
   output logic signed [31:0]                rsp_new_vel_x,
   output logic signed [31:0]                rsp_new_vel_y
);
   import nbv_pkg::*;

   localparam int IW = $clog2(MAX_PARTICLES);

   typedef struct packed {
      logic signed [31:0] p;
      logic signed [31:0] v;
   } pv_type;

   // Mirror a position off the far wall first, then the near wall
   function automatic pv_type reflect(input logic signed [31:0] p,
                                      input logic signed [31:0] v,
                                      input logic [12:0] wall,
                                      input logic [30:0] r);
      logic signed [33:0] hi;
      logic signed [33:0] rr;
      logic signed [33:0] ps;
      pv_type res;
      hi = $signed({5'b0, wall, 16'b0}) - $signed({3'b0, r});
      rr = $signed({3'b0, r});
      ps = 34'(p);
      res.p = p;
      res.v = v;
      if (ps > hi) begin
         res.p = sat32(72'((36'(hi) <<< 1) - 36'(ps)));
         res.v = neg_sat(v);
      end else if (ps < rr) begin
         res.p = sat32(72'((36'(rr) <<< 1) - 36'(ps)));
         res.v = neg_sat(v);
      end
      return res;
   endfunction

   // Load capture
   logic [5:0]         ld_slot_ff;
   logic [30:0]        ld_mass_ff;
   logic [30:0]        ld_r_ff;
   logic signed [31:0] ld_px_ff, ld_py_ff, ld_vx_ff, ld_vy_ff;

   // Multiplier
   logic signed [33:0] ma, mb;
   logic signed [67:0] p_ff;
   logic signed [67:0] p_sh16, p_sh17;

   // Work registers
   logic signed [35:0] mx_ff, my_ff, hx_ff, hy_ff;
   logic signed [31:0] pix_ff, piy_ff;
   logic signed [32:0] dx_ff, dy_ff;
   logic [61:0]        num_ff;
   logic [49:0]        den_ff;
   logic [49:0]        rem_ff;
   logic [30:0]        nsh_ff;
   logic [30:0]        q_ff;
   logic signed [55:0] sx_ff, sy_ff;
   logic signed [32:0] tsx_ff, tsy_ff;
   logic signed [31:0] vx1_ff, vy1_ff;
   logic signed [31:0] opx_ff, opy_ff, ovx_ff, ovy_ff;

   // RAM read data
   logic [31:0] rd_px, rd_py, rd_vx, rd_vy, rd_ax, rd_ay, rd_nax, rd_nay;
   logic [30:0] rd_m, rd_r;

   // RAM write controls
   logic          slot_ok;
   logic          we_pos, we_vel, we_acc, we_nacc, we_ld;
   logic [IW-1:0] waddr;
   logic [31:0]   wd_px, wd_py, wd_vx, wd_vy, wd_ax, wd_ay, wd_nax, wd_nay;

   logic signed [32:0] dx_c, dy_c, mag_x, mag_y;
   logic [30:0]        k_c;
   logic [50:0]        r2;
   pv_type             rfx, rfy;

   assign slot_ok = {1'b0, ld_slot_ff} < 7'(MAX_PARTICLES);
   assign p_sh16  = p_ff >>> 16;
   assign p_sh17  = p_ff >>> 17;

   // Status for the controller
   assign status.den_zero = (den_ff == '0);
   assign status.k_ovf    = ({19'b0, num_ff[61:31]} >= den_ff);

   assign dx_c  = 33'($signed(rd_px)) - 33'(pix_ff);
   assign dy_c  = 33'($signed(rd_py)) - 33'(piy_ff);
   assign mag_x = dx_ff[32] ? -dx_ff : dx_ff;
   assign mag_y = dy_ff[32] ? -dy_ff : dy_ff;
   assign k_c   = status.k_ovf ? K_MAX : q_ff;
   assign r2    = {rem_ff, nsh_ff[30]};

   assign rfx = reflect($signed(rd_px), vx1_ff, cfg.window_width, rd_r);
   assign rfy = reflect($signed(rd_py), vy1_ff, cfg.window_height, rd_r);

   // Select multiplier operands
   always_comb begin
      ma = '0;
      mb = '0;
      case (cmd.op)
         OP_P1_M0: begin
            ma = 34'($signed(rd_vx)); mb = {17'b0, cfg.time_step};
         end
         OP_P1_M1: begin
            ma = 34'($signed(rd_vy)); mb = {17'b0, cfg.time_step};
         end
         OP_P1_M2: begin
            ma = 34'($signed(rd_ax)); mb = {17'b0, cfg.time_step};
         end
         OP_P1_M3: begin
            ma = 34'($signed(rd_ay)); mb = {17'b0, cfg.time_step};
         end
         OP_P1_M4: begin
            ma = 34'(hx_ff); mb = {17'b0, cfg.time_step};
         end
         OP_P1_M5: begin
            ma = 34'(hy_ff); mb = {17'b0, cfg.time_step};
         end
         OP_P2_D: begin
            ma = {3'b0, cfg.grav_const}; mb = {3'b0, rd_m};
         end
         OP_P2_SQX: begin
            ma = {2'b0, mag_x[31:0]}; mb = {2'b0, mag_x[31:0]};
         end
         OP_P2_SQY: begin
            ma = {2'b0, mag_y[31:0]}; mb = {2'b0, mag_y[31:0]};
         end
         OP_P2_KX: begin
            ma = {3'b0, k_c}; mb = 34'(dx_ff);
         end
         OP_P2_KY: begin
            ma = {3'b0, k_c}; mb = 34'(dy_ff);
         end
         OP_P3_MX: begin
            ma = 34'(tsx_ff); mb = {17'b0, cfg.time_step};
         end
         OP_P3_MY: begin
            ma = 34'(tsy_ff); mb = {17'b0, cfg.time_step};
         end
         default: begin
            ma = '0;
            mb = '0;
         end
      endcase
   end

   // Advance datapath registers
   always_ff @(posedge clock) begin
      p_ff <= ma * mb;
      if (cmd.capture) begin
         ld_slot_ff <= req_slot;
         ld_mass_ff <= req_mass;
         ld_r_ff    <= req_radius;
         ld_px_ff   <= req_pos_x;
         ld_py_ff   <= req_pos_y;
         ld_vx_ff   <= req_vel_x;
         ld_vy_ff   <= req_vel_y;
      end
      case (cmd.op)
         OP_P1_M1: mx_ff <= 36'(p_sh16);
         OP_P1_M2: my_ff <= 36'(p_sh16);
         OP_P1_M3: hx_ff <= 36'(p_sh16);
         OP_P1_M4: hy_ff <= 36'(p_sh16);
         OP_P1_M5: mx_ff <= mx_ff + 36'(p_sh17);
         OP_P1_M6: my_ff <= my_ff + 36'(p_sh17);
         OP_P2_LI: begin
            pix_ff <= $signed(rd_px);
            piy_ff <= $signed(rd_py);
            sx_ff  <= '0;
            sy_ff  <= '0;
         end
         OP_P2_D: begin
            dx_ff <= dx_c;
            dy_ff <= dy_c;
         end
         OP_P2_SQX: num_ff <= {p_ff[61:16], 16'b0};
         OP_P2_SQY: den_ff <= {2'b0, p_ff[63:16]} + {19'b0, cfg.softening};
         OP_P2_DEN: den_ff <= den_ff + {2'b0, p_ff[63:16]};
         OP_P2_DIVI: begin
            rem_ff <= {19'b0, num_ff[61:31]};
            nsh_ff <= num_ff[30:0];
            q_ff   <= '0;
         end
         OP_P2_DIV: begin
            nsh_ff <= {nsh_ff[29:0], 1'b0};
            if (r2 >= {1'b0, den_ff}) begin
               rem_ff <= 50'(r2 - {1'b0, den_ff});
               q_ff   <= {q_ff[29:0], 1'b1};
            end else begin
               rem_ff <= r2[49:0];
               q_ff   <= {q_ff[29:0], 1'b0};
            end
         end
         OP_P2_KY:  sx_ff <= sx_ff + 56'(p_sh16);
         OP_P2_ACC: sy_ff <= sy_ff + 56'(p_sh16);
         OP_P3_SUM: begin
            tsx_ff <= 33'($signed(rd_ax)) + 33'($signed(rd_nax));
            tsy_ff <= 33'($signed(rd_ay)) + 33'($signed(rd_nay));
         end
         OP_P3_MY: vx1_ff <= sat32(72'($signed(rd_vx)) + 72'(p_sh17));
         OP_P3_V:  vy1_ff <= sat32(72'($signed(rd_vy)) + 72'(p_sh17));
         OP_P3_RF: begin
            opx_ff <= rfx.p;
            opy_ff <= rfy.p;
            ovx_ff <= rfx.v;
            ovy_ff <= rfy.v;
         end
         default: begin
         end
      endcase
   end

   // Drive store writes
   always_comb begin
      we_ld   = (cmd.op == OP_LOAD) && slot_ok;
      we_pos  = we_ld || (cmd.op == OP_P1_WR) || (cmd.op == OP_P3_RF);
      we_vel  = we_ld || (cmd.op == OP_P3_RF);
      we_acc  = we_vel;
      we_nacc = (cmd.op == OP_P2_WR);
      waddr   = (cmd.op == OP_LOAD) ? ld_slot_ff[IW-1:0] : idx_i;
      wd_nax  = sat32(72'(sx_ff));
      wd_nay  = sat32(72'(sy_ff));
      case (cmd.op)
         OP_LOAD: begin
            wd_px = ld_px_ff; wd_py = ld_py_ff;
            wd_vx = ld_vx_ff; wd_vy = ld_vy_ff;
            wd_ax = '0;       wd_ay = '0;
         end
         OP_P1_WR: begin
            wd_px = sat32(72'($signed(rd_px)) + 72'(mx_ff));
            wd_py = sat32(72'($signed(rd_py)) + 72'(my_ff));
            wd_vx = '0; wd_vy = '0;
            wd_ax = '0; wd_ay = '0;
         end
         default: begin
            wd_px = rfx.p; wd_py = rfy.p;
            wd_vx = rfx.v; wd_vy = rfy.v;
            wd_ax = rd_nax; wd_ay = rd_nay;
         end
      endcase
   end

   nbv_ram #(.WIDTH(32), .DEPTH(MAX_PARTICLES)) u_pos_x (
      .clock(clock), .we(we_pos), .waddr(waddr), .wdata(wd_px),
      .raddr(raddr), .rdata(rd_px));
   nbv_ram #(.WIDTH(32), .DEPTH(MAX_PARTICLES)) u_pos_y (
      .clock(clock), .we(we_pos), .waddr(waddr), .wdata(wd_py),
      .raddr(raddr), .rdata(rd_py));
   nbv_ram #(.WIDTH(32), .DEPTH(MAX_PARTICLES)) u_vel_x (
      .clock(clock), .we(we_vel), .waddr(waddr), .wdata(wd_vx),
      .raddr(raddr), .rdata(rd_vx));
   nbv_ram #(.WIDTH(32), .DEPTH(MAX_PARTICLES)) u_vel_y (
      .clock(clock), .we(we_vel), .waddr(waddr), .wdata(wd_vy),
      .raddr(raddr), .rdata(rd_vy));
   nbv_ram #(.WIDTH(32), .DEPTH(MAX_PARTICLES)) u_acc_x (
      .clock(clock), .we(we_acc), .waddr(waddr), .wdata(wd_ax),
      .raddr(raddr), .rdata(rd_ax));
   nbv_ram #(.WIDTH(32), .DEPTH(MAX_PARTICLES)) u_acc_y (
      .clock(clock), .we(we_acc), .waddr(waddr), .wdata(wd_ay),
      .raddr(raddr), .rdata(rd_ay));
   nbv_ram #(.WIDTH(32), .DEPTH(MAX_PARTICLES)) u_nacc_x (
      .clock(clock), .we(we_nacc), .waddr(waddr), .wdata(wd_nax),
      .raddr(raddr), .rdata(rd_nax));
   nbv_ram #(.WIDTH(32), .DEPTH(MAX_PARTICLES)) u_nacc_y (
      .clock(clock), .we(we_nacc), .waddr(waddr), .wdata(wd_nay),
      .raddr(raddr), .rdata(rd_nay));
   nbv_ram #(.WIDTH(31), .DEPTH(MAX_PARTICLES)) u_mass (
      .clock(clock), .we(we_ld), .waddr(waddr), .wdata(ld_mass_ff),
      .raddr(raddr), .rdata(rd_m));
   nbv_ram #(.WIDTH(31), .DEPTH(MAX_PARTICLES)) u_radius (
      .clock(clock), .we(we_ld), .waddr(waddr), .wdata(ld_r_ff),
      .raddr(raddr), .rdata(rd_r));

   assign rsp_new_pos_x = opx_ff;
   assign rsp_new_pos_y = opy_ff;
   assign rsp_new_vel_x = ovx_ff;
   assign rsp_new_vel_y = ovy_ff;

endmodule

@@ design/nbv_ctrl.sv @@
// ----------------------------------------------------------------------------
// nbv_ctrl: sequencer of the n-body Verlet step
// Walks the drift, pair-force and kick/reflect phases over the particle
// slots and issues one datapath micro-operation per cycle.
// ----------------------------------------------------------------------------
module nbv_ctrl #(
   parameter int MAX_PARTICLES = 64
) (
   input  logic                              clock,
   input  logic                              reset,
   input  logic                              start,
   input  logic                              req_command,
   input  logic [6:0]                        particle_count,
   input  nbv_pkg::dp_status_type            status,
   output logic                              busy,
   output nbv_pkg::dp_cmd_type               cmd,
   output logic [$clog2(MAX_PARTICLES)-1:0]  idx_i,
   output logic [$clog2(MAX_PARTICLES)-1:0]  raddr,
   output logic                              rsp_valid,
   output logic [5:0]                        rsp_out_slot,
   output logic                              rsp_last
);
   import nbv_pkg::*;

   localparam int IW = $clog2(MAX_PARTICLES);
   localparam int NW = $clog2(MAX_PARTICLES + 1);

   typedef enum logic [4:0] {
      S_IDLE, S_LOAD,
      S_P1_RD, S_P1_M0, S_P1_M1, S_P1_M2, S_P1_M3, S_P1_M4, S_P1_M5, S_P1_M6,
      S_P1_WR,
      S_P2_RI, S_P2_LI, S_P2_RJ, S_P2_D, S_P2_SQX, S_P2_SQY, S_P2_DEN,
      S_P2_CHK, S_P2_DIV, S_P2_KX, S_P2_KY, S_P2_ACC, S_P2_WR,
      S_P3_RD, S_P3_SUM, S_P3_MX, S_P3_MY, S_P3_V, S_P3_RF
   } state_type;

   state_type     state_ff, state_in;
   logic [IW-1:0] i_ff, i_in, j_ff, j_in;
   logic [4:0]    d_ff, d_in;
   logic [NW-1:0] n_ff, n_in, n_cfg;
   logic          rsp_valid_ff, rsp_valid_in;
   logic          rsp_last_ff, rsp_last_in;
   logic [5:0]    rsp_slot_ff, rsp_slot_in;
   logic          i_last, j_last;

   assign n_cfg  = (particle_count > 7'(MAX_PARTICLES)) ? NW'(MAX_PARTICLES)
                                                        : NW'(particle_count);
   assign i_last = (NW'(i_ff) + NW'(1)) == n_ff;
   assign j_last = (NW'(j_ff) + NW'(1)) == n_ff;

   // Next state and micro-operation
   always_comb begin
      state_in     = state_ff;
      i_in         = i_ff;
      j_in         = j_ff;
      d_in         = d_ff;
      n_in         = n_ff;
      rsp_valid_in = 1'b0;
      rsp_last_in  = rsp_last_ff;
      rsp_slot_in  = rsp_slot_ff;
      cmd.op       = OP_NONE;
      cmd.capture  = 1'b0;
      raddr        = i_ff;
      case (state_ff)
         S_IDLE: begin
            if (start) begin
               cmd.capture = 1'b1;
               i_in        = '0;
               j_in        = '0;
               n_in        = n_cfg;
               if (req_command == CMD_LOAD) begin
                  state_in = S_LOAD;
               end else if (n_cfg != '0) begin
                  state_in = S_P1_RD;
               end
            end
         end
         S_LOAD: begin
            cmd.op   = OP_LOAD;
            state_in = S_IDLE;
         end
         S_P1_RD: state_in = S_P1_M0;
         S_P1_M0: begin cmd.op = OP_P1_M0; state_in = S_P1_M1; end
         S_P1_M1: begin cmd.op = OP_P1_M1; state_in = S_P1_M2; end
         S_P1_M2: begin cmd.op = OP_P1_M2; state_in = S_P1_M3; end
         S_P1_M3: begin cmd.op = OP_P1_M3; state_in = S_P1_M4; end
         S_P1_M4: begin cmd.op = OP_P1_M4; state_in = S_P1_M5; end
         S_P1_M5: begin cmd.op = OP_P1_M5; state_in = S_P1_M6; end
         S_P1_M6: begin cmd.op = OP_P1_M6; state_in = S_P1_WR; end
         S_P1_WR: begin
            cmd.op = OP_P1_WR;
            if (i_last) begin
               i_in     = '0;
               state_in = S_P2_RI;
            end else begin
               i_in     = i_ff + IW'(1);
               state_in = S_P1_RD;
            end
         end
         S_P2_RI: state_in = S_P2_LI;
         S_P2_LI: begin
            cmd.op   = OP_P2_LI;
            j_in     = '0;
            state_in = S_P2_RJ;
         end
         S_P2_RJ: begin
            raddr = j_ff;
            if (j_ff == i_ff) begin
               // skip the self pair
               if (j_last) begin
                  state_in = S_P2_WR;
               end else begin
                  j_in = j_ff + IW'(1);
               end
            end else begin
               state_in = S_P2_D;
            end
         end
         S_P2_D: begin
            raddr    = j_ff;
            cmd.op   = OP_P2_D;
            state_in = S_P2_SQX;
         end
         S_P2_SQX: begin cmd.op = OP_P2_SQX; state_in = S_P2_SQY; end
         S_P2_SQY: begin cmd.op = OP_P2_SQY; state_in = S_P2_DEN; end
         S_P2_DEN: begin cmd.op = OP_P2_DEN; state_in = S_P2_CHK; end
         S_P2_CHK: begin
            cmd.op = OP_P2_DIVI;
            d_in   = '0;
            if (status.den_zero) begin
               // drop the pair
               if (j_last) begin
                  state_in = S_P2_WR;
               end else begin
                  j_in     = j_ff + IW'(1);
                  state_in = S_P2_RJ;
               end
            end else if (status.k_ovf) begin
               state_in = S_P2_KX;
            end else begin
               state_in = S_P2_DIV;
            end
         end
         S_P2_DIV: begin
            cmd.op = OP_P2_DIV;
            d_in   = d_ff + 5'd1;
            if (d_ff == 5'(DIV_STEPS - 1)) begin
               state_in = S_P2_KX;
            end
         end
         S_P2_KX: begin cmd.op = OP_P2_KX; state_in = S_P2_KY; end
         S_P2_KY: begin cmd.op = OP_P2_KY; state_in = S_P2_ACC; end
         S_P2_ACC: begin
            cmd.op = OP_P2_ACC;
            if (j_last) begin
               state_in = S_P2_WR;
            end else begin
               j_in     = j_ff + IW'(1);
               state_in = S_P2_RJ;
            end
         end
         S_P2_WR: begin
            cmd.op = OP_P2_WR;
            if (i_last) begin
               i_in     = '0;
               state_in = S_P3_RD;
            end else begin
               i_in     = i_ff + IW'(1);
               state_in = S_P2_RI;
            end
         end
         S_P3_RD:  state_in = S_P3_SUM;
         S_P3_SUM: begin cmd.op = OP_P3_SUM; state_in = S_P3_MX; end
         S_P3_MX:  begin cmd.op = OP_P3_MX;  state_in = S_P3_MY; end
         S_P3_MY:  begin cmd.op = OP_P3_MY;  state_in = S_P3_V;  end
         S_P3_V:   begin cmd.op = OP_P3_V;   state_in = S_P3_RF; end
         S_P3_RF: begin
            cmd.op       = OP_P3_RF;
            rsp_valid_in = 1'b1;
            rsp_slot_in  = 6'(i_ff);
            rsp_last_in  = i_last;
            if (i_last) begin
               state_in = S_IDLE;
            end else begin
               i_in     = i_ff + IW'(1);
               state_in = S_P3_RD;
            end
         end
         default: state_in = S_IDLE;
      endcase
   end

   // Hold state, counters and result strobe
   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= S_IDLE;
         i_ff         <= '0;
         j_ff         <= '0;
         d_ff         <= '0;
         n_ff         <= '0;
         rsp_valid_ff <= 1'b0;
         rsp_last_ff  <= 1'b0;
         rsp_slot_ff  <= '0;
      end else begin
         state_ff     <= state_in;
         i_ff         <= i_in;
         j_ff         <= j_in;
         d_ff         <= d_in;
         n_ff         <= n_in;
         rsp_valid_ff <= rsp_valid_in;
         rsp_last_ff  <= rsp_last_in;
         rsp_slot_ff  <= rsp_slot_in;
      end
   end

   assign busy         = (state_ff != S_IDLE);
   assign idx_i        = i_ff;
   assign rsp_valid    = rsp_valid_ff;
   assign rsp_out_slot = rsp_slot_ff;
   assign rsp_last     = rsp_last_ff && rsp_valid_ff;

`ifndef NO_ASSERTIONS
   a_rsp_from_reflect: assert property (@(posedge clock) disable iff (reset)
      rsp_valid_ff |-> $past(state_ff == S_P3_RF))
      else $error("result strobe without a reflect cycle");

   a_div_bound: assert property (@(posedge clock) disable iff (reset)
      (state_ff == S_P2_DIV) |-> (d_ff < 5'(DIV_STEPS)))
      else $error("divider ran past its step count");

   a_index_in_run: assert property (@(posedge clock) disable iff (reset)
      (state_ff != S_IDLE && state_ff != S_LOAD) |->
         (NW'(i_ff) < n_ff && NW'(j_ff) < n_ff))
      else $error("particle index beyond the run length");

   a_last_ends_run: assert property (@(posedge clock) disable iff (reset)
      (rsp_valid_ff && rsp_last_ff) |-> (state_ff == S_IDLE))
      else $error("last result while the step still runs");
`endif

endmodule

@@ design/nbody_verlet_step.sv @@
// A load captures the request and writes it to its slot; a step of n particles walks
//   the drift, pair-force and kick/reflect phases, the pair-force phase running the
//   restoring divider, one quotient bit per cycle, for each pair whose quotient does
//   not overflow. Results come one per particle in the last phase. One item at a time;
//   busy is high meanwhile. Reset clears the controller and restores the register
//   defaults; the particle stores are not cleared. The receiver cannot stall results.
// ----------------------------------------------------------------------------
// nbody_verlet_step: 2D all-pairs gravity step with velocity Verlet update
// Top level: configuration registers, sequencer and datapath.
// ----------------------------------------------------------------------------
module nbody_verlet_step #(
   parameter int MAX_PARTICLES = 64
) (
   input  logic               clock,
   input  logic               reset,
   input  logic               start,
   output logic               busy,
   input  logic               req_command,
   input  logic [5:0]         req_slot,
   input  logic [30:0]        req_mass,
   input  logic signed [31:0] req_pos_x,
   input  logic signed [31:0] req_pos_y,
   input  logic signed [31:0] req_vel_x,
   input  logic signed [31:0] req_vel_y,
   input  logic [30:0]        req_radius,
   output logic               rsp_valid,
   output logic [5:0]         rsp_out_slot,
   output logic signed [31:0] rsp_new_pos_x,
   output logic signed [31:0] rsp_new_pos_y,
   output logic signed [31:0] rsp_new_vel_x,
   output logic signed [31:0] rsp_new_vel_y,
   output logic               rsp_last,
   input  logic               csr_valid,
   output logic               csr_ready,
   input  logic [2:0]         csr_index,
   input  logic [31:0]        csr_wdata
);
   import nbv_pkg::*;

   localparam int IW = $clog2(MAX_PARTICLES);

   cfg_type       cfg_ff;
   logic [6:0]    count_ff;
   dp_cmd_type    cmd;
   dp_status_type status;
   logic [IW-1:0] idx_i, raddr;

   assign csr_ready = 1'b1;

   // Register file writes
   always_ff @(posedge clock) begin
      if (reset) begin
         cfg_ff.time_step     <= 17'd1092;
         cfg_ff.grav_const    <= 31'd65536;
         cfg_ff.softening     <= 31'd65536;
         cfg_ff.window_width  <= 13'd800;
         cfg_ff.window_height <= 13'd600;
         count_ff             <= 7'd64;
      end else if (csr_valid && csr_ready) begin
         case (csr_index)
            REG_TIME_STEP:  cfg_ff.time_step     <= csr_wdata[16:0];
            REG_GRAV_CONST: cfg_ff.grav_const    <= csr_wdata[30:0];
            REG_SOFTENING:  cfg_ff.softening     <= csr_wdata[30:0];
            REG_WIN_WIDTH:  cfg_ff.window_width  <= csr_wdata[12:0];
            REG_WIN_HEIGHT: cfg_ff.window_height <= csr_wdata[12:0];
            REG_PART_COUNT: count_ff             <= csr_wdata[6:0];
            default: begin
            end
         endcase
      end
   end

   nbv_ctrl #(.MAX_PARTICLES(MAX_PARTICLES)) u_ctrl (
      .clock          (clock),
      .reset          (reset),
      .start          (start),
      .req_command    (req_command),
      .particle_count (count_ff),
      .status         (status),
      .busy           (busy),
      .cmd            (cmd),
      .idx_i          (idx_i),
      .raddr          (raddr),
      .rsp_valid      (rsp_valid),
      .rsp_out_slot   (rsp_out_slot),
      .rsp_last       (rsp_last)
   );

   nbv_dp #(.MAX_PARTICLES(MAX_PARTICLES)) u_dp (
      .clock         (clock),
      .cmd           (cmd),
      .idx_i         (idx_i),
      .raddr         (raddr),
      .cfg           (cfg_ff),
      .req_slot      (req_slot),
      .req_mass      (req_mass),
      .req_pos_x     (req_pos_x),
      .req_pos_y     (req_pos_y),
      .req_vel_x     (req_vel_x),
      .req_vel_y     (req_vel_y),
      .req_radius    (req_radius),
      .status        (status),
      .rsp_new_pos_x (rsp_new_pos_x),
      .rsp_new_pos_y (rsp_new_pos_y),
      .rsp_new_vel_x (rsp_new_vel_x),
      .rsp_new_vel_y (rsp_new_vel_y)
   );

endmodule
